// ===== rtl/core/dsrm_pkg.sv =====
// Shared constants, types and helpers for the dot-star regex matcher.
package dsrm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W      = $clog2(MAX_PATTERN);

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] DOT_BYTE  = 8'h2E;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BEGIN = 2'd1,
    FUNC_TEXT  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Control for one step of the shared cell.
  typedef struct packed {
    logic is_text;    // text byte (0: begin, no byte consumed)
    logic first_pos;  // working on pattern position 1
  } step_ctrl_t;

  function automatic logic byte_fits(input logic [7:0] pat, input logic [7:0] c);
    return (pat == DOT_BYTE) || (pat == c);
  endfunction

endpackage

// ===== rtl/core/dsrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dsrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dsrm_cell.sv =====
// One pattern-position update of the prefix-match row.
module dsrm_cell
  import dsrm_pkg::*;
(
  input  step_ctrl_t  ctrl,
  input  logic [7:0]  pat,        // pattern byte at position j-1
  input  logic [7:0]  prev_pat,   // pattern byte at position j-2
  input  logic [7:0]  ch,
  input  logic        old_cur,    // old row bit j
  input  logic        old_prev,   // old row bit j-1
  input  logic        new_back2,  // new row bit j-2
  output logic        new_bit
);

  always_comb begin
    if (pat == STAR_BYTE) begin
      // A star with nothing before it matches nothing.
      if (ctrl.first_pos) begin
        new_bit = 1'b0;
      end else begin
        new_bit = new_back2 | (ctrl.is_text & old_cur & byte_fits(prev_pat, ch));
      end
    end else begin
      new_bit = ctrl.is_text & old_prev & byte_fits(pat, ch);
    end
  end

endmodule

// ===== rtl/core/dot_star_regex_matcher_unit.sv =====
// Top level of the dot-star regex matcher.
//
// Whole-string matcher for patterns of literal bytes, '.' (any byte) and
// '*' (zero or more of the element before it). A load transfer (func 0)
// appends ch_byte to the pattern store, optionally emptying it first with
// clear_pattern; once MAX_PATTERN bytes are held a further byte is dropped
// and its result shows overflow. A begin transfer (func 1) starts a new
// text, and each text transfer (func 2) consumes one text byte; both report
// whether the text so far matches the whole pattern. Every accepted item
// gives exactly one result transfer. A load clears the match row, so text
// bytes after a load and before a new begin report no match. A leading '*'
// matches nothing; a '*' right after a '*' treats the earlier one as a
// literal byte. Func 3 changes nothing and reports zeros.
// Timing: one step cell walks the pattern one position per cycle, reading
// the pattern store through its single registered read port. A begin or
// text item on a non-empty pattern goes through the run state, then done;
// loads, func 3 and items on an empty pattern go straight to done, which is
// left once the previous result has been taken. The result sits in an output
// register, so a new item is accepted while an earlier result still waits.
// After reset the pattern is empty and the row is all zero.
module dot_star_regex_matcher_unit
  import dsrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_ch_byte,
  input  logic       in_clear_pattern,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_overflow
);

  state_t             state_r, state_nxt;
  logic [LEN_W-1:0]   len_r;
  logic [LEN_W-1:0]   pos_r;          // current pattern position j
  logic [MAX_PATTERN:0] row_r;        // prefix-match bits 0..MAX_PATTERN
  logic               is_text_r;
  logic [7:0]         ch_r;
  logic [7:0]         prev_pat_r;     // pattern byte j-2
  logic               old_prev_r;     // old row bit j-1
  logic               new_back1_r;    // new row bit j-1
  logic               new_back2_r;    // new row bit j-2
  logic               res_match_r;
  logic               res_ovf_r;
  logic               out_valid_r;
  logic               out_matched_r;
  logic               out_overflow_r;

  logic               in_xfer;
  logic               out_load;
  logic               run_last;
  func_t              func;
  logic [LEN_W-1:0]   load_base;
  logic               load_fits;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  step_ctrl_t         step_ctrl;
  logic               step_bit;

  assign func      = func_t'(in_func);
  assign in_xfer   = in_valid & in_ready;
  assign run_last  = (pos_r == len_r);
  assign load_base = in_clear_pattern ? '0 : len_r;
  assign load_fits = (load_base < LEN_W'(MAX_PATTERN));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (((func == FUNC_BEGIN) || (func == FUNC_TEXT)) && (len_r != '0)) begin
            state_nxt = ST_RUN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        if (run_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        // Fetch the byte for the next position while this one is worked.
        ram_raddr = pos_r[ADDR_W-1:0];
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  assign ram_we = in_xfer && (func == FUNC_LOAD) && load_fits;

  dsrm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_base[ADDR_W-1:0]),
    .wdata (in_ch_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign step_ctrl.is_text   = is_text_r;
  assign step_ctrl.first_pos = (pos_r == LEN_W'(1));

  dsrm_cell u_cell (
    .ctrl      (step_ctrl),
    .pat       (ram_rdata),
    .prev_pat  (prev_pat_r),
    .ch        (ch_r),
    .old_cur   (row_r[pos_r]),
    .old_prev  (old_prev_r),
    .new_back2 (new_back2_r),
    .new_bit   (step_bit)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        unique case (func)
          FUNC_LOAD: begin
            // Drop the byte when the store is full; the length holds.
            if (load_fits) begin
              len_r <= load_base + LEN_W'(1);
            end else begin
              len_r <= load_base;
            end
            row_r <= '0;
          end
          FUNC_BEGIN: row_r[0] <= 1'b1;
          FUNC_TEXT:  row_r[0] <= 1'b0;
          FUNC_NONE:  ;
        endcase
      end
      if (state_r == ST_RUN) begin
        row_r[pos_r] <= step_bit;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the sweep and the result payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_text_r   <= (func == FUNC_TEXT);
      ch_r        <= in_ch_byte;
      pos_r       <= LEN_W'(1);
      old_prev_r  <= row_r[0];
      new_back1_r <= (func == FUNC_BEGIN);
      new_back2_r <= 1'b0;
      res_match_r <= (func == FUNC_BEGIN) && (len_r == '0);
      res_ovf_r   <= (func == FUNC_LOAD) && !load_fits;
    end
    if (state_r == ST_RUN) begin
      pos_r       <= pos_r + LEN_W'(1);
      prev_pat_r  <= ram_rdata;
      old_prev_r  <= row_r[pos_r];
      new_back2_r <= new_back1_r;
      new_back1_r <= step_bit;
      res_match_r <= step_bit;
    end
    if (out_load) begin
      out_matched_r  <= res_match_r;
      out_overflow_r <= res_ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

endmodule

// ===== rtl/core/dsrm_checker.sv =====
// Port-level checker for the dot-star regex matcher, bound to the top level.
module dsrm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_matched,
  input logic       out_overflow
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched) && $stable(out_overflow))
    else $error("result changed while stalled");

  // Only a load can overflow, and a load never reports a match.
  a_ovf_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_matched)
    else $error("overflow together with match");

  // Every item keeps the block busy in the cycle after its transfer.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in back-to-back cycles");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dot_star_regex_matcher_unit dsrm_checker u_dsrm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_matched  (out_matched),
  .out_overflow (out_overflow)
);
